// File: rtl/core/itf_pkg.sv
// ----------------------------------------------------------------------------
// itf_pkg
// Shared types, character codes and the command/status bundles that join the
// integer text formatter's controller and datapath.
// ----------------------------------------------------------------------------
package itf_pkg;

  // Port widths fixed by the interface
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned FW_W    = 6;
  localparam int unsigned PREC_W  = 7;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned LEN_W   = 6;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_LOWA  = 8'h61;

  typedef enum logic [1:0] {
    KIND_SPACE,
    KIND_MINUS,
    KIND_ZERO,
    KIND_DIGIT
  } char_kind_e;

  typedef struct packed {
    logic       load;   // capture the input item
    logic       conv;   // one binary-to-BCD step
    logic       size;   // work out pad, sign and digit counts
    logic       emit;   // drive one character into the output register
    char_kind_e kind;
  } cmd_t;

  typedef struct packed {
    logic conv_done;
    logic spc_zero;
    logic neg_pend;
    logic zro_zero;
    logic rem_zero;
    logic out_free;
  } sts_t;

  // Digit value to its lowercase ASCII code
  function automatic logic [CHAR_W-1:0] digit_char(logic [3:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = CH_LOWA + {4'd0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

// File: rtl/core/itf_ctrl.sv
// ----------------------------------------------------------------------------
// itf_ctrl
// Sequencer for the formatter: accept, convert, size, then emit characters
// in the order spaces, sign, zero fill, digits.
// ----------------------------------------------------------------------------
module itf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  itf_pkg::sts_t sts_i,
  output itf_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.kind  = itf_pkg::KIND_SPACE;
    in_stall_o  = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        if (sts_i.conv_done) begin
          state_d = ST_SIZE;
        end else begin
          cmd_o.conv = 1'b1;
        end
      end
      ST_SIZE: begin
        cmd_o.size = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.rem_zero) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          priority if (!sts_i.spc_zero) begin
            cmd_o.kind = itf_pkg::KIND_SPACE;
          end else if (sts_i.neg_pend) begin
            cmd_o.kind = itf_pkg::KIND_MINUS;
          end else if (!sts_i.zro_zero) begin
            cmd_o.kind = itf_pkg::KIND_ZERO;
          end else begin
            cmd_o.kind = itf_pkg::KIND_DIGIT;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/itf_dp.sv
// ----------------------------------------------------------------------------
// itf_dp
// Formatter datapath: magnitude, shift-add-3 BCD converter, length math,
// pad counters and the output register.
// ----------------------------------------------------------------------------
module itf_dp #(
  parameter int unsigned MAX_FIELD  = 63,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          mode_i,
  input  logic [itf_pkg::VALUE_W-1:0]   value_i,
  input  logic [itf_pkg::FW_W-1:0]      field_width_i,
  input  logic signed [itf_pkg::PREC_W-1:0] precision_i,
  input  itf_pkg::cmd_t                 cmd_i,
  output itf_pkg::sts_t                 sts_o,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [itf_pkg::CHAR_W-1:0]    character_o,
  output logic                          last_o,
  output logic [itf_pkg::LEN_W-1:0]     total_length_o
);

  localparam int unsigned LW        = itf_pkg::LEN_W;
  localparam int unsigned FIELD_CAP = (MAX_FIELD > 63) ? 63 : MAX_FIELD;
  // decimal digits of the largest magnitude (1233/4096 ~ log10(2))
  localparam int unsigned NUM_DIG   = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int unsigned BCD_W     = NUM_DIG * 4;
  localparam int unsigned SH_W      = BCD_W + VALUE_BITS;
  localparam int unsigned NDW       = $clog2(NUM_DIG + 1);
  localparam int unsigned IDW       = (NUM_DIG > 1) ? $clog2(NUM_DIG) : 1;
  localparam int unsigned CNT_W     = $clog2(VALUE_BITS + 1);
  localparam logic [LW-1:0]    CAP   = LW'(FIELD_CAP);
  localparam logic [CNT_W-1:0] STEPS = CNT_W'(VALUE_BITS);

  // ---- input capture ----
  logic [VALUE_BITS-1:0] v_in, mag_in;
  logic                  neg_in;
  logic [LW-1:0]         width_in, praw_in, prec_in;

  assign v_in     = value_i[VALUE_BITS-1:0];
  assign neg_in   = !mode_i && v_in[VALUE_BITS-1];
  assign mag_in   = neg_in ? ((~v_in) + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : v_in;
  assign width_in = (field_width_i > CAP) ? CAP : field_width_i;
  assign praw_in  = precision_i[LW-1:0];
  assign prec_in  = precision_i[itf_pkg::PREC_W-1] ? '0 :
                    ((praw_in > CAP) ? CAP : praw_in);

  logic          mode_q, neg_q, given_q;
  logic [LW-1:0] width_q, prec_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_i;
      neg_q   <= neg_in;
      given_q <= !precision_i[itf_pkg::PREC_W-1];
      width_q <= width_in;
      prec_q  <= prec_in;
    end
  end

  // ---- BCD converter: {bcd, binary} shifted left, add 3 to digits >= 5 ----
  logic [SH_W-1:0] sh_q, sh_adj;

  always_comb begin
    sh_adj = sh_q;
    for (int i = 0; i < NUM_DIG; i++) begin
      if (sh_q[VALUE_BITS + 4*i +: 4] >= 4'd5) begin
        sh_adj[VALUE_BITS + 4*i +: 4] = sh_q[VALUE_BITS + 4*i +: 4] + 4'd3;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      // hex digits are just the nibbles of the magnitude
      sh_q <= mode_i ? {BCD_W'(mag_in), {VALUE_BITS{1'b0}}}
                     : {{BCD_W{1'b0}}, mag_in};
    end else if (cmd_i.conv) begin
      sh_q <= {sh_adj[SH_W-2:0], 1'b0};
    end
  end

  logic [3:0] dig_arr [NUM_DIG];

  always_comb begin
    for (int i = 0; i < NUM_DIG; i++) begin
      dig_arr[i] = sh_q[VALUE_BITS + 4*i +: 4];
    end
  end

  // ---- sizing ----
  logic [NDW-1:0] ndig;
  logic           any_nz, nodig;
  logic [LW-1:0]  len, body, spc_n, zro_n, total_n;

  always_comb begin
    ndig   = NDW'(1);
    any_nz = 1'b0;
    for (int i = 0; i < NUM_DIG; i++) begin
      if (dig_arr[i] != 4'd0) begin
        ndig   = NDW'(i + 1);
        any_nz = 1'b1;
      end
    end
    nodig   = given_q && (prec_q == '0) && !any_nz;
    len     = nodig ? '0 : (LW'(ndig) + LW'(neg_q));
    body    = (len > prec_q) ? len : prec_q;
    spc_n   = (width_q > body) ? (width_q - body) : '0;
    zro_n   = (prec_q > len) ? (prec_q - len) : '0;
    total_n = spc_n + body;
  end

  // ---- emission counters ----
  logic [CNT_W-1:0] cnt_q;
  logic [LW-1:0]    spc_q, zro_q, rem_q, total_q;
  logic [NDW-1:0]   dig_q;
  logic             negp_q, valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      spc_q   <= '0;
      zro_q   <= '0;
      rem_q   <= '0;
      total_q <= '0;
      dig_q   <= '0;
      negp_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.conv) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.size) begin
        spc_q   <= spc_n;
        zro_q   <= zro_n;
        rem_q   <= total_n;
        total_q <= total_n;
        dig_q   <= nodig ? '0 : ndig;
        negp_q  <= neg_q;
      end else if (cmd_i.emit) begin
        rem_q <= rem_q - LW'(1);
        unique case (cmd_i.kind)
          itf_pkg::KIND_SPACE: spc_q  <= spc_q - LW'(1);
          itf_pkg::KIND_MINUS: negp_q <= 1'b0;
          itf_pkg::KIND_ZERO:  zro_q  <= zro_q - LW'(1);
          itf_pkg::KIND_DIGIT: dig_q  <= dig_q - NDW'(1);
          default:             negp_q <= negp_q;
        endcase
      end
      if (cmd_i.emit) begin
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // ---- output beat ----
  logic [NDW-1:0]              dig_idx;
  logic [itf_pkg::CHAR_W-1:0]  char_d, char_q;
  logic                        last_d, last_q;
  logic [LW-1:0]               len_q;

  assign dig_idx = dig_q - NDW'(1);
  assign last_d  = (rem_q == LW'(1));

  always_comb begin
    unique case (cmd_i.kind)
      itf_pkg::KIND_SPACE: char_d = itf_pkg::CH_SPACE;
      itf_pkg::KIND_MINUS: char_d = itf_pkg::CH_MINUS;
      itf_pkg::KIND_ZERO:  char_d = itf_pkg::CH_ZERO;
      itf_pkg::KIND_DIGIT: char_d = itf_pkg::digit_char(dig_arr[dig_idx[IDW-1:0]]);
      default:             char_d = itf_pkg::CH_SPACE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      char_q <= char_d;
      last_q <= last_d;
      len_q  <= last_d ? total_q : '0;
    end
  end

  assign sts_o.conv_done = mode_q || (cnt_q == STEPS);
  assign sts_o.spc_zero  = (spc_q == '0);
  assign sts_o.neg_pend  = negp_q;
  assign sts_o.zro_zero  = (zro_q == '0);
  assign sts_o.rem_zero  = (rem_q == '0);
  assign sts_o.out_free  = !valid_q || !out_stall_i;

  assign out_valid_o    = valid_q;
  assign character_o    = char_q;
  assign last_o         = last_q;
  assign total_length_o = len_q;

endmodule

// File: rtl/core/integer_text_formatter.sv
// ----------------------------------------------------------------------------
// integer_text_formatter
// Formats one integer as %d or %x text, one ASCII character per output beat.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-------------------------------------
//  in      | in  | in_valid_i/in_stall_o | mode_i value_i field_width_i
//          |     |                       | precision_i
//  out     | out | out_valid_o/          | character_o last_o total_length_o
//          |     | out_stall_i           |
//
// In decimal mode the bit-serial BCD converter takes one input bit per cycle;
// hex mode needs no conversion, its digits being the nibbles of the
// magnitude. Every character goes out through the single output register.
// One item is in work at a time; in_stall_o is high from acceptance through
// the cycle after the last beat has been loaded into the output register.
// Output stall freezes emission; reset clears the sequencer and counters.
// ----------------------------------------------------------------------------
module integer_text_formatter #(
  parameter int unsigned MAX_FIELD  = 63,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              mode_i,
  input  logic [itf_pkg::VALUE_W-1:0]       value_i,
  input  logic [itf_pkg::FW_W-1:0]          field_width_i,
  input  logic signed [itf_pkg::PREC_W-1:0] precision_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [itf_pkg::CHAR_W-1:0]        character_o,
  output logic                              last_o,
  output logic [itf_pkg::LEN_W-1:0]         total_length_o
);

  itf_pkg::cmd_t cmd;
  itf_pkg::sts_t sts;

  itf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itf_dp #(
    .MAX_FIELD  (MAX_FIELD),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (mode_i),
    .value_i        (value_i),
    .field_width_i  (field_width_i),
    .precision_i    (precision_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .character_o    (character_o),
    .last_o         (last_o),
    .total_length_o (total_length_o)
  );

  // accepted item keeps the input side closed next cycle
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o
  ) else $error("input not stalled after accept");

  a_last_has_length: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> total_length_o != '0
  ) else $error("last beat without length");

  a_mid_no_length: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> total_length_o == '0
  ) else $error("length on non-last beat");

  // while idle only the final beat of the previous item can be pending
  a_idle_only_last: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_stall_o |-> last_o
  ) else $error("idle with a non-last beat pending");

endmodule

// File: tb/sv/integer_text_formatter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_text_formatter_checker
// Watches both channels of the formatter. Each accepted number is expanded
// into the characters it should produce. Each output beat is compared,
// field by field, with the oldest character still due.
// ----------------------------------------------------------------------------
module integer_text_formatter_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic                              mode_i,
  input  logic [itf_pkg::VALUE_W-1:0]       value_i,
  input  logic [itf_pkg::FW_W-1:0]          field_width_i,
  input  logic signed [itf_pkg::PREC_W-1:0] precision_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [itf_pkg::CHAR_W-1:0]        character_i,
  input  logic                              last_i,
  input  logic [itf_pkg::LEN_W-1:0]         total_length_i,
  output int                                mismatch_count_o,
  output int                                chars_due_o
);

  localparam int FIELD_CAP = 63;

  typedef struct packed {
    logic [itf_pkg::CHAR_W-1:0] ch;
    logic                       last;
    logic [itf_pkg::LEN_W-1:0]  len;
  } char_beat_t;

  char_beat_t chars_due[$];

  // Expand one number into its %d / %x characters
  task automatic format_number(input logic hex,
                               input logic [itf_pkg::VALUE_W-1:0] value,
                               input logic [itf_pkg::FW_W-1:0] fw,
                               input logic [itf_pkg::PREC_W-1:0] prec_raw);
    char_beat_t                 text[$];
    logic [itf_pkg::CHAR_W-1:0] digit_text[0:39];
    logic [itf_pkg::VALUE_W-1:0] mag;
    logic [itf_pkg::VALUE_W-1:0] rest;
    logic [3:0]                 d;
    logic                       neg;
    logic                       no_digits;
    int                         base, ndig, len, body, width, prec, last_idx;

    width = fw;
    prec  = prec_raw[itf_pkg::PREC_W-1] ? -1 : int'(prec_raw);
    if (prec > FIELD_CAP) prec = FIELD_CAP;
    if (width > FIELD_CAP) width = FIELD_CAP;
    base = hex ? 16 : 10;
    neg  = !hex && value[itf_pkg::VALUE_W-1];
    mag  = neg ? -value : value;  // most negative maps onto itself, read unsigned

    ndig = 0;
    rest = mag;
    do begin
      d = 4'(rest % base);
      digit_text[ndig] = (d < 4'd10) ? itf_pkg::CH_ZERO + d
                                     : itf_pkg::CH_LOWA + (d - 4'd10);
      ndig++;
      rest = rest / base;
    end while (rest != 0);

    no_digits = (prec == 0) && (mag == 0);
    len  = no_digits ? 0 : ndig + (neg ? 1 : 0);
    body = (len > prec) ? len : prec;

    for (int i = 0; i < width - body && text.size() < FIELD_CAP; i++)
      text.push_back('{itf_pkg::CH_SPACE, 1'b0, '0});
    if (neg && text.size() < FIELD_CAP)
      text.push_back('{itf_pkg::CH_MINUS, 1'b0, '0});
    for (int i = 0; i < prec - len && text.size() < FIELD_CAP; i++)
      text.push_back('{itf_pkg::CH_ZERO, 1'b0, '0});
    if (!no_digits) begin
      for (int i = ndig - 1; i >= 0 && text.size() < FIELD_CAP; i--)
        text.push_back('{digit_text[i], 1'b0, '0});
    end

    if (text.size() > 0) begin
      last_idx = text.size() - 1;
      text[last_idx].last = 1'b1;
      text[last_idx].len  = itf_pkg::LEN_W'(text.size());
    end
    foreach (text[i]) chars_due.push_back(text[i]);
  endtask

  task automatic check_char();
    char_beat_t want;
    if (chars_due.size() == 0) begin
      $error("unexpected beat: character %h last %b total_length %0d",
             character_i, last_i, total_length_i);
      mismatch_count_o++;
    end else begin
      want = chars_due.pop_front();
      if (character_i !== want.ch) begin
        $error("character: expected %h, got %h", want.ch, character_i);
        mismatch_count_o++;
      end
      if (last_i !== want.last) begin
        $error("last: expected %b, got %b", want.last, last_i);
        mismatch_count_o++;
      end
      if (total_length_i !== want.len) begin
        $error("total_length: expected %0d, got %0d", want.len, total_length_i);
        mismatch_count_o++;
      end
    end
  endtask

  // output side first, so a stray beat is never matched against a new number
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      mismatch_count_o = 0;
      chars_due_o      = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_char();
      if (in_valid_i && !in_stall_i)
        format_number(mode_i, value_i, field_width_i, precision_i);
      chars_due_o = chars_due.size();
    end
  end

endmodule

// File: tb/sv/integer_text_formatter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_text_formatter_tb
// Drives the formatter with directed corner numbers and then random ones,
// under three idle/stall mixes, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module integer_text_formatter_tb;

  localparam logic [itf_pkg::PREC_W-1:0] NO_PREC = 7'h7f;

  logic                                clk_i;
  logic                                rst_ni         = 1'b0;
  logic                                in_valid_i     = 1'b0;
  logic                                in_stall_o;
  logic                                mode_i         = 1'b0;
  logic [itf_pkg::VALUE_W-1:0]         value_i        = '0;
  logic [itf_pkg::FW_W-1:0]            field_width_i  = '0;
  logic signed [itf_pkg::PREC_W-1:0]   precision_i    = '0;
  logic                                out_valid_o;
  logic                                out_stall_i    = 1'b0;
  logic [itf_pkg::CHAR_W-1:0]          character_o;
  logic                                last_o;
  logic [itf_pkg::LEN_W-1:0]           total_length_o;

  int mismatch_count;
  int chars_due;
  int tx_idle_pct = 31;
  int rx_stall_pct = 57;

  integer_text_formatter uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .value_i        (value_i),
    .field_width_i  (field_width_i),
    .precision_i    (precision_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .character_o    (character_o),
    .last_o         (last_o),
    .total_length_o (total_length_o)
  );

  integer_text_formatter_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .mode_i           (mode_i),
    .value_i          (value_i),
    .field_width_i    (field_width_i),
    .precision_i      (precision_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .character_i      (character_o),
    .last_i           (last_o),
    .total_length_i   (total_length_o),
    .mismatch_count_o (mismatch_count),
    .chars_due_o      (chars_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_stall_pct);
  end

  task automatic send_number(input logic hex, input logic [itf_pkg::VALUE_W-1:0] value,
                             input logic [itf_pkg::FW_W-1:0] fw,
                             input logic [itf_pkg::PREC_W-1:0] prec);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= hex;
    value_i       <= value;
    field_width_i <= fw;
    precision_i   <= prec;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_random_number();
    logic [itf_pkg::VALUE_W-1:0] value;
    logic [itf_pkg::FW_W-1:0]    fw;
    logic [itf_pkg::PREC_W-1:0]  prec;
    case ($urandom_range(7))
      0: value = $urandom_range(9);
      1: value = $urandom_range(999);
      2: value = $urandom >> $urandom_range(31);
      3: value = -($urandom >> $urandom_range(31));
      4: begin
        case ($urandom_range(3))
          0: value = 32'h0;
          1: value = 32'hffff_ffff;
          2: value = 32'h8000_0000;
          default: value = 32'h7fff_ffff;
        endcase
      end
      default: value = $urandom;
    endcase
    // mostly short fields, now and then up to the cap
    fw = ($urandom_range(9) < 8) ? itf_pkg::FW_W'($urandom_range(16))
                                 : itf_pkg::FW_W'($urandom_range(63));
    case ($urandom_range(9))
      0, 1: prec = NO_PREC;
      2: prec = itf_pkg::PREC_W'($urandom_range(64, 127));
      3: prec = '0;
      4: prec = itf_pkg::PREC_W'($urandom_range(63));
      default: prec = itf_pkg::PREC_W'($urandom_range(12));
    endcase
    send_number(1'($urandom_range(1)), value, fw, prec);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_number(1'b0, 32'd0, 6'd0, NO_PREC);
    send_number(1'b0, 32'd0, 6'd0, 7'd0);         // empty item
    send_number(1'b1, 32'd0, 6'd0, 7'd0);         // empty item
    send_number(1'b0, 32'd0, 6'd5, 7'd0);         // spaces only
    send_number(1'b0, 32'hffff_fffb, 6'd0, 7'd3); // sign counts toward precision
    send_number(1'b0, 32'h8000_0000, 6'd0, NO_PREC);
    send_number(1'b0, 32'h7fff_ffff, 6'd0, NO_PREC);
    send_number(1'b1, 32'hffff_ffff, 6'd0, NO_PREC);
    send_number(1'b1, 32'h0, 6'd0, NO_PREC);
    send_number(1'b0, 32'hffff_ffff, 6'd63, 7'd62);
    send_number(1'b0, 32'd12345, 6'd63, 7'd63);   // widest output
    send_number(1'b1, 32'hdead_beef, 6'd63, 7'd63);
    send_number(1'b0, 32'd42, 6'd10, NO_PREC);
    send_number(1'b1, 32'hdead_beef, 6'd12, 7'd10);
    send_number(1'b0, 32'd7, 6'd0, 7'h40);        // other negative precisions
    send_number(1'b1, 32'd7, 6'd4, 7'h55);
    send_number(1'b1, 32'habcd_ef01, 6'd3, NO_PREC);
    send_number(1'b0, -32'sd123, 6'd8, 7'd6);
    send_number(1'b0, 32'd5, 6'd0, 7'd1);
    send_number(1'b0, 32'd1, 6'd2, 7'd5);
    send_number(1'b1, 32'h8000_0000, 6'd9, 7'd0);

    for (int n = 0; n < 140; n++) begin
      if (n == 47) begin
        tx_idle_pct  = 57;
        rx_stall_pct = 31;
      end
      if (n == 94) begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      send_random_number();
    end
    in_valid_i <= 1'b0;

    while (chars_due != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (mismatch_count == 0 && chars_due == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
